>>> hdl/kmer_edit_ball_center_assign_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the k-mer edit-ball centre assignment block
// Implication checks clocked on a rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KMER_EDIT_BALL_CENTER_ASSIGN_ASSERT_SVH
`define KMER_EDIT_BALL_CENTER_ASSIGN_ASSERT_SVH

// same-cycle implication
`define KEBCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kebca: implication check failed");

// next-cycle implication
`define KEBCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kebca: next-cycle check failed");

`endif

>>> hdl/kebca_pkg.sv
// ----------------------------------------------------------------------------
// kebca_pkg
// Types and constants shared by the edit-ball centre assignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package kebca_pkg;

    localparam int CFG_W   = 4;   // width of each configuration register
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W  = 4;
    localparam int DEPTH_W = 5;   // layer counter, holds radius + 1

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 2'd1;

    localparam logic [CFG_W-1:0] KMER_LENGTH_RESET   = 4'd8;
    localparam logic [CFG_W-1:0] SEARCH_RADIUS_RESET = 4'd2;

    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic KIND_WALK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] kmer_value;
        logic [15:0] center_number;
    } req_t;

    typedef struct packed {
        logic        answer_kind;
        logic        assigned;
        logic [15:0] nearest_center;
        logic [3:0]  distance;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VCLR,
        S_PROBE,
        S_CHECK,
        S_LAYER,
        S_LOAD,
        S_LWAIT,
        S_QREAD,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_DEL,
        PH_SUB,
        PH_INS
    } phase_t;

    typedef struct packed {
        logic idle;
        logic tab_clr;
        logic vis_clr;
        logic accept_walk;
        logic check;
        logic layer_step;
        logic latch_node;
        logic emit_walk;
        logic emit_query;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic init;
        logic last_nbr;
        logic more_nodes;
        logic walk_end;
        logic next_empty;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/kebca_ram.sv
// ----------------------------------------------------------------------------
// kebca_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kebca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/kebca_ctrl.sv
// ----------------------------------------------------------------------------
// kebca_ctrl
// Sequencer: clearing sweeps, neighbour probing, layer hand-over, replies.
// ----------------------------------------------------------------------------
`default_nettype none

module kebca_ctrl
    import kebca_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    mode,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.tab_clr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (start)
                begin
                    if (mode == MODE_QUERY)
                    begin
                        state_next = S_QREAD;
                    end
                    else
                    begin
                        cmd.accept_walk = 1'b1;
                        state_next      = S_VCLR;
                    end
                end
            end
            S_VCLR:
            begin
                cmd.vis_clr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.init)
                begin
                    state_next = S_LAYER;
                end
                else if (!status.last_nbr)
                begin
                    state_next = S_PROBE;
                end
                else if (status.more_nodes)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_LAYER;
                end
            end
            S_LAYER:
            begin
                cmd.layer_step = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_FIN;
                end
                else if (!status.next_empty)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                cmd.latch_node = 1'b1;
                state_next     = S_PROBE;
            end
            S_QREAD:
            begin
                cmd.emit_query = 1'b1;
                state_next     = S_IDLE;
            end
            S_FIN:
            begin
                cmd.emit_walk = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/kebca_dp.sv
// ----------------------------------------------------------------------------
// kebca_dp
// Datapath: assignment table, visited marks, ping-pong frontiers, counters.
// ----------------------------------------------------------------------------
`default_nettype none

module kebca_dp
    import kebca_pkg::*;
#(
    parameter int MAX_K             = 8,
    parameter int CENTER_INDEX_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire req_t             req,
    input  wire logic [CFG_W-1:0] k_eff,
    input  wire logic [CFG_W-1:0] radius_eff,
    input  wire cmd_t             cmd,
    output status_t               status,
    output logic                  done,
    output rsp_t                  rsp
);

    localparam int FULL_AW  = 2 * MAX_K;
    localparam int SHORT_AW = (MAX_K > 1) ? 2 * MAX_K - 2 : 1;
    localparam int FULL_D   = 1 << FULL_AW;
    localparam int SHORT_D  = 1 << SHORT_AW;
    localparam int FR_D     = FULL_D + SHORT_D;
    localparam int FR_AW    = $clog2(FR_D);
    localparam int CNT_W    = $clog2(FR_D + 1);
    localparam int ENT_W    = FULL_AW + 1;
    localparam int CW       = CENTER_INDEX_BITS;
    localparam int TAB_W    = 1 + CW + DIST_W;

    // walk registers
    logic [FULL_AW-1:0] sweep_reg;
    logic [FULL_AW-1:0] kv_reg;
    logic [CW-1:0]      center_reg;
    logic [ENT_W-1:0]   node_reg;
    logic [CFG_W-1:0]   j_reg;
    logic [1:0]         m_reg;
    phase_t             phase_reg;
    logic               init_reg;
    logic [DEPTH_W-1:0] d_reg;
    logic [CNT_W-1:0]   i_reg, cur_cnt_reg, fcnt_reg;
    logic               sel_reg;
    logic               done_reg;
    rsp_t               rsp_reg;

    // k-mask and masked request fields
    logic [31:0]        kmask32, kv32, ctr32;
    logic [FULL_AW-1:0] req_kv;
    assign kmask32 = (32'd1 << {k_eff, 1'b0}) - 32'd1;
    assign kv32    = 32'(req.kmer_value) & kmask32;
    assign req_kv  = kv32[FULL_AW-1:0];
    assign ctr32   = 32'(req.center_number);

    // neighbour generation
    logic [4:0]         sh;
    logic [31:0]        s32, tail32, del32, sub32, ins32, m32;
    logic               cand_short;
    logic [FULL_AW-1:0] cand_val;
    assign sh     = {j_reg, 1'b0};
    assign s32    = 32'(node_reg[FULL_AW-1:0]);
    assign m32    = 32'(m_reg) << sh;
    assign tail32 = s32 & ((32'd1 << sh) - 32'd1);
    assign del32  = ((s32 >> (sh + 5'd2)) << sh) | tail32;
    assign sub32  = ((s32 & ~(32'd3 << sh)) | m32) & kmask32;
    assign ins32  = (((s32 >> sh) << (sh + 5'd2)) | m32 | tail32) & kmask32;

    always_comb
    begin
        cand_short = 1'b0;
        cand_val   = kv_reg;
        if (!init_reg)
        begin
            case (phase_reg)
                PH_DEL:
                begin
                    cand_short = 1'b1;
                    cand_val   = del32[FULL_AW-1:0];
                end
                PH_SUB:  cand_val = sub32[FULL_AW-1:0];
                PH_INS:  cand_val = ins32[FULL_AW-1:0];
                default: cand_val = kv_reg;
            endcase
        end
    end

    // assignment table
    logic               tab_we;
    logic [FULL_AW-1:0] tab_waddr, tab_raddr;
    logic [TAB_W-1:0]   tab_wdata, tab_rdata;
    logic               tab_valid;
    logic [CW-1:0]      tab_center;
    logic [DIST_W-1:0]  tab_dist;
    assign {tab_valid, tab_center, tab_dist} = tab_rdata;

    // visited marks
    logic               vis_full_rd, vis_short_rd, visited;
    logic               vf_we, vs_we, vis_wdata;
    logic [FULL_AW-1:0] vf_addr;
    logic [SHORT_AW-1:0] vs_addr;
    assign visited = cand_short ? vis_short_rd : vis_full_rd;

    // frontiers
    logic [ENT_W-1:0]   fr_wdata, fa_rdata, fb_rdata, fr_rdata;
    logic               push, fa_we, fb_we;
    logic [FR_AW-1:0]   fr_waddr, fr_raddr;
    assign fr_rdata = sel_reg ? fb_rdata : fa_rdata;
    assign fr_wdata = {cand_short, cand_val};
    assign fr_waddr = fcnt_reg[FR_AW-1:0];
    assign fr_raddr = i_reg[FR_AW-1:0];
    assign push     = cmd.check && !visited && (fcnt_reg < CNT_W'(FR_D));
    assign fa_we    = push && sel_reg;
    assign fb_we    = push && !sel_reg;

    logic offer;
    assign offer = !tab_valid || (tab_dist > d_reg[DIST_W-1:0]);

    always_comb
    begin
        tab_we    = 1'b0;
        tab_waddr = cand_val;
        tab_wdata = {1'b1, center_reg, d_reg[DIST_W-1:0]};
        tab_raddr = cmd.idle ? req_kv : cand_val;
        vf_we     = 1'b0;
        vs_we     = 1'b0;
        vis_wdata = 1'b1;
        vf_addr   = cand_val;
        vs_addr   = cand_val[SHORT_AW-1:0];
        if (cmd.tab_clr)
        begin
            tab_we    = 1'b1;
            tab_waddr = sweep_reg;
            tab_wdata = '0;
        end
        else if (cmd.vis_clr)
        begin
            vf_we     = 1'b1;
            vs_we     = 1'b1;
            vis_wdata = 1'b0;
            vf_addr   = sweep_reg;
            vs_addr   = sweep_reg[SHORT_AW-1:0];
        end
        else if (cmd.check && !visited)
        begin
            vf_we  = !cand_short;
            vs_we  = cand_short;
            tab_we = !cand_short && offer;
        end
    end

    kebca_ram #(.WIDTH(TAB_W), .DEPTH(FULL_D)) u_tab (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    kebca_ram #(.WIDTH(1), .DEPTH(FULL_D)) u_vis_full (
        .clk(clk), .we(vf_we), .waddr(vf_addr), .wdata(vis_wdata),
        .raddr(vf_addr), .rdata(vis_full_rd)
    );

    kebca_ram #(.WIDTH(1), .DEPTH(SHORT_D)) u_vis_short (
        .clk(clk), .we(vs_we), .waddr(vs_addr), .wdata(vis_wdata),
        .raddr(vs_addr), .rdata(vis_short_rd)
    );

    kebca_ram #(.WIDTH(ENT_W), .DEPTH(FR_D)) u_front_a (
        .clk(clk), .we(fa_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fa_rdata)
    );

    kebca_ram #(.WIDTH(ENT_W), .DEPTH(FR_D)) u_front_b (
        .clk(clk), .we(fb_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fb_rdata)
    );

    // status
    logic [DEPTH_W-1:0] d_inc;
    logic               j_last;
    assign d_inc  = d_reg + DEPTH_W'(1);
    assign j_last = (j_reg == k_eff - CFG_W'(1));

    assign status.sweep_last = &sweep_reg;
    assign status.init       = init_reg;
    assign status.last_nbr   = (phase_reg != PH_DEL) && (m_reg == 2'd3) && j_last;
    assign status.more_nodes = (i_reg + CNT_W'(1)) < cur_cnt_reg;
    assign status.walk_end   = d_inc > DEPTH_W'(radius_eff);
    assign status.next_empty = (fcnt_reg == '0);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            init_reg    <= 1'b0;
            d_reg       <= '0;
            i_reg       <= '0;
            cur_cnt_reg <= '0;
            fcnt_reg    <= '0;
            sel_reg     <= 1'b0;
            j_reg       <= '0;
            m_reg       <= '0;
            phase_reg   <= PH_DEL;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_walk || cmd.emit_query;
            if (cmd.tab_clr || cmd.vis_clr)
            begin
                sweep_reg <= sweep_reg + FULL_AW'(1);
            end
            if (cmd.accept_walk)
            begin
                init_reg <= 1'b1;
                d_reg    <= '0;
                fcnt_reg <= '0;
            end
            if (push)
            begin
                fcnt_reg <= fcnt_reg + CNT_W'(1);
            end
            if (cmd.check)
            begin
                if (init_reg)
                begin
                    init_reg <= 1'b0;
                end
                else if (status.last_nbr)
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                else if (phase_reg == PH_DEL)
                begin
                    if (j_last)
                    begin
                        phase_reg <= PH_SUB;
                        j_reg     <= '0;
                        m_reg     <= '0;
                    end
                    else
                    begin
                        j_reg <= j_reg + CFG_W'(1);
                    end
                end
                else
                begin
                    m_reg <= m_reg + 2'd1;
                    if (m_reg == 2'd3)
                    begin
                        j_reg <= j_reg + CFG_W'(1);
                    end
                end
            end
            if (cmd.layer_step)
            begin
                d_reg       <= d_inc;
                sel_reg     <= !sel_reg;
                cur_cnt_reg <= fcnt_reg;
                fcnt_reg    <= '0;
                i_reg       <= '0;
            end
            if (cmd.latch_node)
            begin
                j_reg     <= '0;
                m_reg     <= '0;
                phase_reg <= fr_rdata[ENT_W-1] ? PH_INS : PH_DEL;
            end
        end
    end

    // payload registers
    logic [31:0] tab_center32;
    assign tab_center32 = 32'(tab_center);

    always_ff @(posedge clk)
    begin
        if (cmd.accept_walk)
        begin
            kv_reg     <= req_kv;
            center_reg <= ctr32[CW-1:0];
        end
        if (cmd.latch_node)
        begin
            node_reg <= fr_rdata;
        end
        if (cmd.emit_walk)
        begin
            rsp_reg <= '{answer_kind: KIND_WALK, assigned: 1'b0,
                         nearest_center: 16'd0, distance: 4'd0};
        end
        else if (cmd.emit_query)
        begin
            rsp_reg.answer_kind    <= KIND_QUERY;
            rsp_reg.assigned       <= tab_valid;
            rsp_reg.nearest_center <= tab_valid ? tab_center32[15:0] : 16'd0;
            rsp_reg.distance       <= tab_valid ? tab_dist : 4'd0;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> hdl/kmer_edit_ball_center_assign.sv
// Query: accepted when idle; the table is read, then the answer is registered and strobed on done.
// Centre walk: a sweep clearing the 4^MAX_K visited marks, then a probe and a check for
// each neighbour (about 5k per frontier node) plus a load for each node taken from the frontier.
// Each neighbour needs both states because the visited and table RAMs have a registered read.
// Reset starts a clearing pass over all 4^MAX_K table entries; busy is high.
// ----------------------------------------------------------------------------
// kmer_edit_ball_center_assign
// Nearest-centre table for k-mers, filled by breadth-first edit-ball walks.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_edit_ball_center_assign
    import kebca_pkg::*;
#(
    parameter int MAX_K             = 8,
    parameter int MAX_RADIUS        = 15,
    parameter int CENTER_INDEX_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request side
    input  wire logic                 start,
    input  wire req_t                 req,
    output logic                      busy,
    // result side, one-cycle strobe, no back-pressure
    output logic                      done,
    output rsp_t                      rsp,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    `include "kmer_edit_ball_center_assign_assert.svh"

    // configuration registers
    logic [CFG_W-1:0] kmer_length_reg, search_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg   <= KMER_LENGTH_RESET;
            search_radius_reg <= SEARCH_RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KMER_LENGTH:   kmer_length_reg   <= cfg_data;
                CFG_SEARCH_RADIUS: search_radius_reg <= cfg_data;
                default:           ;  // unknown index ignored
            endcase
        end
    end

    // k of zero acts as one; k and radius saturate at their bounds
    logic [CFG_W-1:0] k_eff, radius_eff;
    assign k_eff = (kmer_length_reg == '0) ? CFG_W'(1) :
                   (32'(kmer_length_reg) > MAX_K) ? CFG_W'(MAX_K) : kmer_length_reg;
    assign radius_eff = (32'(search_radius_reg) > MAX_RADIUS) ? CFG_W'(MAX_RADIUS)
                                                              : search_radius_reg;

    cmd_t    cmd;
    status_t status;

    kebca_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (req.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    kebca_dp #(
        .MAX_K             (MAX_K),
        .CENTER_INDEX_BITS (CENTER_INDEX_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .k_eff      (k_eff),
        .radius_eff (radius_eff),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .rsp        (rsp)
    );

    // an accepted request always leaves idle
    `KEBCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // results are single-cycle and arrive once back in idle
    `KEBCA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `KEBCA_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    // walk completions carry no assignment
    `KEBCA_ASSERT_IMPL(a_walk_empty, clk, rst_n, done && (rsp.answer_kind == KIND_WALK),
                       !rsp.assigned && (rsp.nearest_center == 16'd0))

endmodule

`default_nettype wire
